// ===== hw/rtl/rlfg_pkg.sv =====
// Shared types, constants and the color wheel for the rainbow LED frame generator.
package rlfg_pkg;

  // Field widths
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned IVAL_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  // Parameter defaults
  localparam int unsigned LED_COUNT_DEF  = 64;
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_IVAL   = 1'b1;

  // Reset value of the frame interval
  localparam logic [IVAL_W-1:0] FRAME_IVAL_RST = 16'd20;

  // Wheel segment bounds
  localparam logic [7:0] SEG1 = 8'd85;
  localparam logic [7:0] SEG2 = 8'd170;
  localparam logic [7:0] FULL = 8'd255;

  typedef enum logic {
    MODE_RAINBOW = 1'b0,
    MODE_CHASE   = 1'b1
  } mode_e;

  // One frame job handed from front to back
  typedef struct packed {
    mode_e      mode;
    logic [7:0] offset;
    logic [1:0] phase;
  } frame_t;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } rgb_t;

  // Three-segment color wheel
  function automatic rgb_t wheel(logic [7:0] pos);
    rgb_t       c;
    logic [7:0] p;
    logic [7:0] p3;
    if (pos < SEG1) begin
      p = pos;
    end else if (pos < SEG2) begin
      p = pos - SEG1;
    end else begin
      p = pos - SEG2;
    end
    p3 = 8'(p * 8'd3);
    if (pos < SEG1) begin
      c.red   = p3;
      c.green = FULL - p3;
      c.blue  = '0;
    end else if (pos < SEG2) begin
      c.red   = FULL - p3;
      c.green = '0;
      c.blue  = p3;
    end else begin
      c.red   = '0;
      c.green = p3;
      c.blue  = FULL - p3;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rlfg_front.sv =====
// Front end: config registers, frame timer and frame job classification.
module rlfg_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [rlfg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rlfg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // timestamp stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rlfg_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [31:0] now_ms
  // frame job queue
  input  logic                             full_i,
  output logic                             push_o,
  output rlfg_pkg::frame_t                 frame_o
);

  rlfg_pkg::mode_e                 mode_q;
  logic [rlfg_pkg::IVAL_W-1:0]     ival_q;
  logic [7:0]                      offset_q;
  logic [1:0]                      phase_q;
  logic                            running_q;
  logic [rlfg_pkg::TIME_W-1:0]     start_q;

  logic [rlfg_pkg::TIME_W-1:0]     now;
  logic [rlfg_pkg::TIME_W-1:0]     elapsed;
  logic                            due;
  logic [7:0]                      eff_offset;
  logic [1:0]                      phase_next;

  assign s_axis_tready = !full_i;
  assign now           = s_axis_tdata[rlfg_pkg::TIME_W-1:0];

  // Due check: unsigned wrapping elapsed time against interval
  assign elapsed = now - start_q;
  assign due     = !running_q || (elapsed >= {{(rlfg_pkg::TIME_W-rlfg_pkg::IVAL_W){1'b0}}, ival_q});

  // Chase restarts the wheel while the timer was never started
  assign eff_offset = (mode_q == rlfg_pkg::MODE_CHASE && !running_q) ? 8'd0 : offset_q;
  assign phase_next = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;

  assign push_o         = s_axis_tvalid && s_axis_tready && due;
  assign frame_o.mode   = mode_q;
  assign frame_o.offset = eff_offset;
  assign frame_o.phase  = phase_q;

  // Config and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= rlfg_pkg::MODE_RAINBOW;
      ival_q    <= rlfg_pkg::FRAME_IVAL_RST;
      offset_q  <= '0;
      phase_q   <= '0;
      running_q <= 1'b0;
      start_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rlfg_pkg::REG_PATTERN_MODE: mode_q <= rlfg_pkg::mode_e'(cfg_data_i[0]);
          rlfg_pkg::REG_FRAME_IVAL:   ival_q <= cfg_data_i[rlfg_pkg::IVAL_W-1:0];
          default: ;
        endcase
      end
      if (push_o) begin
        running_q <= 1'b1;
        start_q   <= now;
        if (mode_q == rlfg_pkg::MODE_RAINBOW) begin
          offset_q <= eff_offset + 8'd1;
        end else begin
          phase_q  <= phase_next;
          offset_q <= (phase_next == 2'd0) ? eff_offset + 8'd1 : eff_offset;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("chase phase out of range");
`endif

endmodule

// ===== hw/rtl/rlfg_fifo.sv =====
// Short queue of frame jobs between front and back.
module rlfg_fifo #(
  parameter int unsigned DEPTH = rlfg_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rlfg_pkg::frame_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output rlfg_pkg::frame_t data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rlfg_pkg::frame_t   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("frame job pushed into full queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count over depth");
`endif

endmodule

// ===== hw/rtl/rlfg_back.sv =====
// Back end: pixel sequencer and registered output word.
module rlfg_back #(
  parameter int unsigned LED_COUNT = rlfg_pkg::LED_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // frame job queue
  input  logic                             empty_i,
  input  rlfg_pkg::frame_t                 frame_i,
  output logic                             pop_o,
  // pixel stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rlfg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // led_index, red, green, blue
  output logic                             m_axis_tlast   // frame_last
);

  localparam int unsigned CNT_W  = $clog2(LED_COUNT + 3);
  localparam int unsigned REM_W  = $clog2(LED_COUNT);
  localparam int unsigned Q_STEP = 256 / LED_COUNT;
  localparam int unsigned R_STEP = 256 % LED_COUNT;
  localparam int unsigned PAD_W  = rlfg_pkg::OUT_DATA_W - rlfg_pkg::IDX_W - 3 * rlfg_pkg::LVL_W;

  logic                         act_q;
  rlfg_pkg::frame_t             frm_q;
  logic [CNT_W-1:0]             i_q;
  logic                         sub_q;
  logic [7:0]                   q_q;
  logic [REM_W-1:0]             rem_q;

  logic                         out_vld_q;
  logic [rlfg_pkg::IDX_W-1:0]   out_idx_q;
  rlfg_pkg::rgb_t               out_rgb_q;
  logic                         out_last_q;

  logic                         adv;
  logic [CNT_W-1:0]             lit_sum;
  logic [CNT_W-1:0]             lit;
  logic [CNT_W-1:0]             clr;
  logic [REM_W:0]               rem_sum;
  logic                         rem_wrap;
  logic                         rb_last;
  logic                         ch_last;
  logic [rlfg_pkg::IDX_W-1:0]   pix_idx;
  rlfg_pkg::rgb_t               pix_rgb;
  logic                         pix_last;

  assign adv   = !out_vld_q || m_axis_tready;
  assign pop_o = !act_q && !empty_i;

  // Chase indexes: lit LED and the one before it
  assign lit_sum = i_q + CNT_W'(frm_q.phase);
  assign lit     = (lit_sum >= CNT_W'(LED_COUNT)) ? lit_sum - CNT_W'(LED_COUNT) : lit_sum;
  assign clr     = (lit == '0) ? CNT_W'(LED_COUNT - 1) : lit - CNT_W'(1);

  // Rainbow position: running quotient and remainder of i*256/LED_COUNT
  assign rem_sum  = {1'b0, rem_q} + (REM_W+1)'(R_STEP);
  assign rem_wrap = rem_sum >= (REM_W+1)'(LED_COUNT);

  assign rb_last = (i_q == CNT_W'(LED_COUNT - 1));
  assign ch_last = sub_q && ({1'b0, i_q} + (CNT_W+1)'(3) >= (CNT_W+1)'(LED_COUNT));

  // Pixel for the current step
  always_comb begin
    if (frm_q.mode == rlfg_pkg::MODE_RAINBOW) begin
      pix_idx  = rlfg_pkg::IDX_W'(i_q);
      pix_rgb  = rlfg_pkg::wheel(q_q + frm_q.offset);
      pix_last = rb_last;
    end else if (!sub_q) begin
      pix_idx  = rlfg_pkg::IDX_W'(lit);
      pix_rgb  = rlfg_pkg::wheel(8'(i_q) + frm_q.offset);
      pix_last = 1'b0;
    end else begin
      pix_idx  = rlfg_pkg::IDX_W'(clr);
      pix_rgb  = '0;
      pix_last = ch_last;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      frm_q <= '0;
      i_q   <= '0;
      sub_q <= 1'b0;
      q_q   <= '0;
      rem_q <= '0;
    end else if (pop_o) begin
      act_q <= 1'b1;
      frm_q <= frame_i;
      i_q   <= '0;
      sub_q <= 1'b0;
      q_q   <= '0;
      rem_q <= '0;
    end else if (act_q && adv) begin
      if (pix_last) begin
        act_q <= 1'b0;
      end
      if (frm_q.mode == rlfg_pkg::MODE_RAINBOW) begin
        i_q <= i_q + CNT_W'(1);
        if (rem_wrap) begin
          rem_q <= REM_W'(rem_sum - (REM_W+1)'(LED_COUNT));
          q_q   <= q_q + 8'(Q_STEP + 1);
        end else begin
          rem_q <= REM_W'(rem_sum);
          q_q   <= q_q + 8'(Q_STEP);
        end
      end else begin
        sub_q <= !sub_q;
        if (sub_q) begin
          i_q <= i_q + CNT_W'(3);
        end
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && act_q) begin
      out_idx_q  <= pix_idx;
      out_rgb_q  <= pix_rgb;
      out_last_q <= pix_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_rgb_q.blue, out_rgb_q.green, out_rgb_q.red,
                          out_idx_q};

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (lit < CNT_W'(LED_COUNT)) && (i_q < CNT_W'(LED_COUNT)))
    else $error("LED index past the strip");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < REM_W'(LED_COUNT - 1) || rem_q == REM_W'(LED_COUNT - 1))
    else $error("rainbow remainder out of range");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> act_q)
    else $error("job popped but sequencer not started");
`endif

endmodule

// ===== hw/rtl/rainbow_led_frame_generator.sv =====
// Top level of the rainbow LED frame generator.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata[31:0] now_ms
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata idx/red/green/blue, tlast
//  cfg       in   cfg_we_i                        cfg_idx_i, cfg_data_i[15:0]
//
// A due timestamp queues a frame job; the back end loads a job only when idle.
// The back end emits one pixel word per cycle unless m_axis_tready stalls it:
// LED_COUNT words for a rainbow frame, 2*ceil(LED_COUNT/3) for a chase frame.
// s_axis_tready drops only while the FIFO_DEPTH-entry job queue is full.
// Output stalls back up into the job queue; no clearing pass after reset.
module rainbow_led_frame_generator #(
  parameter int unsigned LED_COUNT  = rlfg_pkg::LED_COUNT_DEF,
  parameter int unsigned FIFO_DEPTH = rlfg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rlfg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rlfg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rlfg_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [31:0] now_ms
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] led_index, [13:6] red_level, [21:14] green_level, [29:22] blue_level
  output logic [rlfg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast    // frame_last
);

  logic             push, full, pop, empty;
  rlfg_pkg::frame_t frm_in, frm_out;

  rlfg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .frame_o       (frm_in)
  );

  rlfg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (frm_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (frm_out),
    .empty_o (empty)
  );

  rlfg_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .frame_i       (frm_out),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
